>>> design/fprp_pkg.sv
// Shared definitions for the floating-point round-and-pack pipeline.
// Holds the rounding mode and shift direction encodings; depends on nothing else.
package fprp_pkg;

  typedef enum logic [2:0] {
    RM_RNE = 3'd0,
    RM_RNA = 3'd1,
    RM_RUP = 3'd2,
    RM_RDN = 3'd3,
    RM_RTZ = 3'd4
  } round_mode_e;

  typedef enum logic [1:0] {
    SH_LEFT  = 2'd0,
    SH_RIGHT = 2'd1,
    SH_ZERO  = 2'd2
  } shift_dir_e;

endpackage

>>> design/fp_round_and_pack.sv
// Round-and-pack pipeline for IEEE-style floating-point results.
// Uses fprp_pkg for the rounding mode and shift direction codes.
//
// Channel | Signals                                   | Direction
// input   | in_valid_i, in_ready_o, round_mode_i,     | in
//         | sign_i, significand_i, exponent_i         |
// output  | out_valid_o, out_ready_i, packed_result_o | out
//
// One transaction enters per cycle while in_ready_o is high; it passes through the
// leading-zero stage, the shift-planning stage and the shift stage, then the
// rounding stage registers the result. Reset clears only the valid bits.
// All stages advance together whenever the output register is empty or taken.
module fp_round_and_pack #(
  parameter int EXP_WIDTH = 8,
  parameter int SIG_WIDTH = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             round_mode_i,
  input  logic                   sign_i,
  input  logic [SIG_WIDTH+3:0]   significand_i,
  input  logic [EXP_WIDTH+1:0]   exponent_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [31:0]            packed_result_o
);

  localparam int XW = EXP_WIDTH + 2;
  localparam int SB = SIG_WIDTH + 4;
  localparam int PW = EXP_WIDTH + SIG_WIDTH;
  localparam int HALF = 1 << (EXP_WIDTH - 1);
  localparam logic [XW-1:0] EMAX_W = XW'(HALF - 1);
  localparam logic [XW-1:0] EMIN_W = XW'(2 - HALF);
  localparam logic [EXP_WIDTH-1:0] EMIN_E = EXP_WIDTH'(2 - HALF);
  localparam logic [EXP_WIDTH-1:0] EMAX_E = EXP_WIDTH'(HALF - 1);
  localparam logic [XW-1:0] CAP_W = XW'(SIG_WIDTH + 2);

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q;

  assign adv = !v4_q || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Stage 1: leading zeros and early overflow.
  logic [2:0]    rm1_q;
  logic          sg1_q, ovf1_q, ovf1_d;
  logic [SB-1:0] sig1_q;
  logic [XW-1:0] ex1_q, lz1_q, lz1_d;

  always_comb begin
    lz1_d = XW'(SB);
    for (int i = 0; i < SB; i++) begin
      if (significand_i[i]) begin
        lz1_d = XW'(SB - 1 - i);
      end
    end
    ovf1_d = (!exponent_i[XW-1] && (exponent_i[XW-2] || exponent_i[XW-3])) ||
             (exponent_i == EMAX_W && significand_i[SB-1]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rm1_q  <= round_mode_i;
      sg1_q  <= sign_i;
      sig1_q <= significand_i;
      ex1_q  <= exponent_i;
      lz1_q  <= lz1_d;
      ovf1_q <= ovf1_d;
    end
  end

  // Stage 2: tininess and shift planning.
  logic [2:0]    rm2_q;
  logic          sg2_q, ovf2_q;
  logic [SB-1:0] sig2_q;
  logic [XW-1:0] ex2_q, ex2_d, t2, sigma2, neg2;
  logic [XW:0]   sh2_q, sh2_d;
  logic          tiny2;
  fprp_pkg::shift_dir_e dir2_q, dir2_d;

  always_comb begin
    t2     = ex1_q + XW'(1) - lz1_q - EMIN_W;
    tiny2  = t2[XW-1];
    sigma2 = tiny2 ? (ex1_q - EMIN_W + XW'(1)) : lz1_q;
    neg2   = XW'(0) - sigma2;
    ex2_d  = tiny2 ? {{(XW-EXP_WIDTH){EMIN_E[EXP_WIDTH-1]}}, EMIN_E}
                   : (ex1_q - lz1_q + XW'(1));
    if (sigma2[XW-1]) begin
      dir2_d = fprp_pkg::SH_RIGHT;
      sh2_d  = {1'b0, (neg2 <= CAP_W) ? neg2 : CAP_W} + (XW+1)'(2);
    end else if ({1'b0, sigma2} >= (XW+1)'(SB)) begin
      dir2_d = fprp_pkg::SH_ZERO;
      sh2_d  = '0;
    end else begin
      dir2_d = fprp_pkg::SH_LEFT;
      sh2_d  = {1'b0, sigma2};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rm2_q  <= rm1_q;
      sg2_q  <= sg1_q;
      ovf2_q <= ovf1_q;
      sig2_q <= sig1_q;
      ex2_q  <= ex2_d;
      sh2_q  <= sh2_d;
      dir2_q <= dir2_d;
    end
  end

  // Stage 3: normalizing shift with sticky fold.
  logic [2:0]    rm3_q;
  logic          sg3_q, ovf3_q;
  logic [XW-1:0] ex3_q;
  logic [SB-1:0] s3_q, s3_d, v3, top3, msk3;

  always_comb begin
    v3   = sig2_q << sh2_q;
    msk3 = ~({SB{1'b1}} << sh2_q);
    top3 = sig2_q >> sh2_q;
    case (dir2_q)
      fprp_pkg::SH_RIGHT: s3_d = top3 | SB'(|(sig2_q & msk3));
      fprp_pkg::SH_LEFT:  s3_d = (v3 >> 2) | SB'(|v3[1:0]);
      default:            s3_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rm3_q  <= rm2_q;
      sg3_q  <= sg2_q;
      ovf3_q <= ovf2_q;
      ex3_q  <= ex2_q;
      s3_q   <= s3_d;
    end
  end

  // Stage 4: round, post-normalize, bias and pack.
  logic                 inc4, ros4, sovf4, ovfr4, tomax4;
  logic [SIG_WIDTH:0]   sum4;
  logic [SIG_WIDTH-1:0] m4;
  logic [XW-1:0]        exf4;
  logic [EXP_WIDTH-1:0] bexp4, rexp4;
  logic [SIG_WIDTH-2:0] rfrac4;
  logic [PW+31:0]       full4;
  logic [31:0]          res_q;

  always_comb begin
    ros4 = s3_q[1] | s3_q[0];
    case (rm3_q)
      fprp_pkg::RM_RNE: inc4 = s3_q[1] & (s3_q[2] | s3_q[0]);
      fprp_pkg::RM_RNA: inc4 = s3_q[1];
      fprp_pkg::RM_RUP: inc4 = !sg3_q & ros4;
      fprp_pkg::RM_RDN: inc4 = sg3_q & ros4;
      default:          inc4 = 1'b0;
    endcase
    sum4  = {1'b0, s3_q[SB-3:2]} + (SIG_WIDTH+1)'(inc4);
    sovf4 = sum4[SIG_WIDTH];
    m4    = sovf4 ? sum4[SIG_WIDTH:1] : sum4[SIG_WIDTH-1:0];
    exf4  = ex3_q + XW'(sovf4);
    bexp4 = exf4[EXP_WIDTH-1:0] + EMAX_E;
    ovfr4 = ovf3_q || (sovf4 && (&bexp4));
    tomax4 = (rm3_q == fprp_pkg::RM_RTZ) ||
             (!sg3_q && rm3_q == fprp_pkg::RM_RDN) ||
             (sg3_q && rm3_q == fprp_pkg::RM_RUP);
    if (ovfr4) begin
      rexp4  = tomax4 ? {{(EXP_WIDTH-1){1'b1}}, 1'b0} : '1;
      rfrac4 = tomax4 ? '1 : '0;
    end else begin
      rexp4  = m4[SIG_WIDTH-1] ? bexp4 : '0;
      rfrac4 = m4[SIG_WIDTH-2:0];
    end
    full4 = {32'b0, sg3_q, rexp4, rfrac4};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= full4[31:0];
    end
  end

  assign packed_result_o = res_q;

endmodule
